@@ rtl/lfy_pkg.sv @@
// Shared types and constants of the LCG-driven Fisher-Yates shuffler.
// No dependencies; every other file of the block refers to this package.
package lfy_pkg;

  // Widths fixed by the ports.
  localparam int PORT_W = 32;
  localparam int SEED_W = 32;
  // A count field wide enough for the largest supported store depth.
  localparam int CNT_W  = 7;
  // Bits of the generator used as the random draw.
  localparam int RAND_W = 16;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;

  // Command codes passed from the front end to the engine.
  localparam logic [1:0] OP_STORE      = 2'd0;
  localparam logic [1:0] OP_DROP       = 2'd1;
  localparam logic [1:0] OP_STORE_LAST = 2'd2;
  localparam logic [1:0] OP_DROP_LAST  = 2'd3;

  // For a plain store, count is the slot to write; for a last beat it is the
  // list length after this beat.
  typedef struct packed {
    logic [1:0]        op;
    logic [PORT_W-1:0] element;
    logic [CNT_W-1:0]  count;
    logic              ovf;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_flags_t;

endpackage

@@ rtl/lcg_fisher_yates_shuffle.sv @@
// Top level of the LCG-driven Fisher-Yates list shuffler.
// Depends on lfy_pkg, lfy_front, lfy_fifo and lfy_back.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------
//  input   | in_valid / in_stall       | element, last
//  output  | out_valid / out_stall     | element_res, last_res, overflow
//  config  | cfg_we                    | cfg_wdata (seed)
//
// Elements are taken one beat a cycle while the two-entry command queue has room.
// A list of n elements then takes n-1 swap steps, each an LCG multiply, a
// bit-serial modulo of the 16-bit draw, a two-port read and a swap on the single
// write port; then each result is read from the store and loaded for output.
// Synchronous reset empties the queue and output register; the store needs no
// clearing pass. A stalled output holds its beat while the front keeps filling.
module lcg_fisher_yates_shuffle #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lfy_pkg::SEED_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lfy_pkg::PORT_W-1:0] element,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lfy_pkg::PORT_W-1:0] element_res,
  output logic                       last_res,
  output logic                       overflow
);

  lfy_pkg::cmd_t        front_cmd;
  lfy_pkg::cmd_t        head;
  lfy_pkg::fifo_flags_t flags;
  logic                 push;
  logic                 pop;

  lfy_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .element  (element),
    .last     (last),
    .flags    (flags),
    .push     (push),
    .cmd      (front_cmd)
  );

  lfy_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .head   (head),
    .flags  (flags)
  );

  lfy_back #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .head        (head),
    .flags       (flags),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .element_res (element_res),
    .last_res    (last_res),
    .overflow    (overflow)
  );

`ifndef SYNTHESIS
  // A stalled result stays on offer with its payload unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(element_res) &&
      $stable(last_res) && $stable(overflow))
    else $error("stalled result changed or was withdrawn");

  // A push into a queue holding one entry, with no pop, must fill it.
  a_fifo_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop && !flags.empty |=> flags.full)
    else $error("command queue did not report full");

  // A pop from a full queue, with no push, leaves exactly one entry.
  a_fifo_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push && flags.full |=> !flags.full && !flags.empty)
    else $error("command queue level wrong after pop");

  // Reset leaves the queue empty and no result on offer.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && flags.empty)
    else $error("state not cleared by reset");
`endif

endmodule

@@ rtl/lfy_front.sv @@
// Front end: takes input beats, tracks the list length and overflow, and
// turns each beat into a command. Depends on lfy_pkg.
module lfy_front #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lfy_pkg::PORT_W-1:0] element,
  input  logic                       last,
  input  lfy_pkg::fifo_flags_t       flags,
  output logic                       push,
  output lfy_pkg::cmd_t              cmd
);

  localparam int CW    = $clog2(DEPTH) + 1;
  localparam int CNT_W = lfy_pkg::CNT_W;

  logic [CW-1:0] count;
  logic          ovf_seen;
  logic          has_room;
  logic [CW-1:0] count_field;

  assign has_room = count < CW'(DEPTH);
  assign in_stall = flags.full;
  assign push     = in_valid && !flags.full;

  always_comb begin
    cmd.element = element;
    if (last) begin
      cmd.op      = has_room ? lfy_pkg::OP_STORE_LAST : lfy_pkg::OP_DROP_LAST;
      count_field = has_room ? count + CW'(1) : count;
      cmd.ovf     = ovf_seen || !has_room;
    end else begin
      cmd.op      = has_room ? lfy_pkg::OP_STORE : lfy_pkg::OP_DROP;
      count_field = count;
      cmd.ovf     = ovf_seen;
    end
    cmd.count = CNT_W'(count_field);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (push) begin
      if (last) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end else if (has_room) begin
        count <= count + CW'(1);
      end else begin
        ovf_seen <= 1'b1;
      end
    end
  end

endmodule

@@ rtl/lfy_fifo.sv @@
// Two-entry command queue between the front end and the shuffle engine.
// Depends on lfy_pkg for the command and flag types.
module lfy_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lfy_pkg::cmd_t        wr_cmd,
  input  logic                 pop,
  output lfy_pkg::cmd_t        head,
  output lfy_pkg::fifo_flags_t flags
);

  lfy_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    level;

  assign head        = slots[rd_ptr];
  assign flags.full  = level == 2'd2;
  assign flags.empty = level == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        level <= level + 2'd1;
      end else if (pop && !push) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule

@@ rtl/lfy_back.sv @@
// Shuffle engine: element store, LCG, bit-serial modulo, swap sequencer and
// output register. Depends on lfy_pkg.
module lfy_back #(
  parameter int DEPTH      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lfy_pkg::SEED_W-1:0] cfg_wdata,
  input  lfy_pkg::cmd_t              head,
  input  lfy_pkg::fifo_flags_t       flags,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lfy_pkg::PORT_W-1:0] element_res,
  output logic                       last_res,
  output logic                       overflow
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = AW + 1;
  localparam int PW  = lfy_pkg::PORT_W;
  localparam int SW  = (ELEM_WIDTH < PW) ? ELEM_WIDTH : PW;
  localparam int RW  = lfy_pkg::RAND_W;
  localparam int BW  = $clog2(RW);
  localparam int LW  = lfy_pkg::SEED_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LCG  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_SW1  = 3'd4;
  localparam logic [2:0] ST_SW2  = 3'd5;
  localparam logic [2:0] ST_ORD  = 3'd6;
  localparam logic [2:0] ST_OWR  = 3'd7;

  logic [2:0]    state;
  logic [LW-1:0] seed;
  logic [LW-1:0] lcg;
  logic [LW-1:0] lcg_next;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] k;
  logic [CW-1:0] n;
  logic          ovf_list;
  logic [RW-1:0] dvd;
  logic [BW-1:0] bitcnt;
  logic [SW-1:0] rd_a;
  logic [SW-1:0] rd_b;
  logic [SW-1:0] mem [DEPTH];

  logic          is_store;
  logic          is_last;
  logic [CW-1:0] head_cnt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [AW-1:0] rd_addr_a;
  logic [CW-1:0] divisor;
  logic [CW-1:0] rem_sh;
  logic [CW-1:0] rem_sub;
  logic          out_load;

  assign pop      = (state == ST_IDLE) && !flags.empty;
  assign head_cnt = head.count[CW-1:0];
  assign is_store = (head.op == lfy_pkg::OP_STORE) || (head.op == lfy_pkg::OP_STORE_LAST);
  assign is_last  = (head.op == lfy_pkg::OP_STORE_LAST) || (head.op == lfy_pkg::OP_DROP_LAST);
  assign lcg_next = LW'(lcg * lfy_pkg::LCG_MUL + lfy_pkg::LCG_ADD);

  // One bit of the restoring division of the draw by i+1 per cycle.
  assign divisor = {1'b0, i} + CW'(1);
  assign rem_sh  = {j, dvd[RW-1]};
  assign rem_sub = rem_sh - divisor;

  assign out_load  = (state == ST_OWR) && (!out_valid || !out_stall);
  assign rd_addr_a = (state == ST_ORD) ? k : i;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i;
    wr_data = rd_b;
    unique case (state)
      ST_IDLE: begin
        wr_en   = pop && is_store;
        wr_addr = is_last ? AW'(head_cnt - CW'(1)) : AW'(head_cnt);
        wr_data = head.element[SW-1:0];
      end
      ST_SW1: begin
        wr_en   = 1'b1;
        wr_addr = i;
        wr_data = rd_b;
      end
      ST_SW2: begin
        wr_en   = 1'b1;
        wr_addr = j;
        wr_data = rd_a;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if ((state == ST_READ) || (state == ST_ORD)) begin
      rd_a <= mem[rd_addr_a];
    end
    if (state == ST_READ) begin
      rd_b <= mem[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop && is_last) begin
            n        <= head_cnt;
            ovf_list <= head.ovf;
            lcg      <= seed;
            k        <= '0;
            if (head_cnt < CW'(2)) begin
              state <= ST_ORD;
            end else begin
              i     <= AW'(head_cnt - CW'(1));
              state <= ST_LCG;
            end
          end
        end
        ST_LCG: begin
          lcg    <= lcg_next;
          dvd    <= lcg_next[LW-1:LW-RW];
          j      <= '0;
          bitcnt <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          j      <= (rem_sh >= divisor) ? AW'(rem_sub) : AW'(rem_sh);
          dvd    <= dvd << 1;
          bitcnt <= bitcnt + BW'(1);
          if (bitcnt == BW'(RW - 1)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_SW1;
        end
        ST_SW1: begin
          state <= ST_SW2;
        end
        ST_SW2: begin
          if (i == AW'(1)) begin
            state <= ST_ORD;
          end else begin
            i     <= i - AW'(1);
            state <= ST_LCG;
          end
        end
        ST_ORD: begin
          state <= ST_OWR;
        end
        ST_OWR: begin
          if (out_load) begin
            if ({1'b0, k} == n - CW'(1)) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= ST_ORD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      element_res <= PW'(rd_a);
      last_res    <= {1'b0, k} == n - CW'(1);
      overflow    <= ovf_list;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for lcg_fisher_yates_shuffle: drives lists of elements,
// predicts each shuffled list in-line and checks every output beat field by field.
// Depends on lfy_pkg and the RTL of the block; nothing else.
module testbench;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 500;
  localparam int DIR_N       = 14;
  localparam logic [31:0] GEN_MUL = 32'd1103515245;
  localparam logic [31:0] GEN_INC = 32'd12345;

  typedef struct packed {
    logic [lfy_pkg::PORT_W-1:0] element;
    logic                       last;
    logic                       ovf;
  } shuf_beat_t;

  typedef struct packed {
    logic [lfy_pkg::PORT_W-1:0] element;
    logic                       last;
    logic                       typed;
    logic [lfy_pkg::PORT_W-1:0] res_element;
    logic                       res_last;
    logic                       res_ovf;
  } stim_row_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [lfy_pkg::SEED_W-1:0] cfg_wdata = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic [lfy_pkg::PORT_W-1:0] element   = '0;
  logic                       last      = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [lfy_pkg::PORT_W-1:0] element_res;
  logic                       last_res;
  logic                       overflow;

  shuf_beat_t        expected_beats [$];
  logic [31:0]       held_list [$];
  bit                held_lost   = 1'b0;
  logic [31:0]       gen_seed    = '0;
  int                faults      = 0;
  int                cycle_count = 0;
  bit                tx_eager    = 1'b0;
  bit                rx_eager    = 1'b0;
  bit                hold_output = 1'b0;

  lcg_fisher_yates_shuffle #(.DEPTH(DEPTH), .ELEM_WIDTH(32)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .element    (element),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .element_res(element_res),
    .last_res   (last_res),
    .overflow   (overflow)
  );

  always #5 clk = ~clk;

  // Stores one element and, on the closing beat, shuffles the held list with
  // the generator restarted from the seed and, when emit is set, queues the whole list.
  function automatic void shuffle_list(input logic [31:0] value, input bit is_last,
                                       input bit emit);
    logic [31:0] work [$];
    logic [31:0] gen;
    logic [31:0] tmp;
    int          n;
    int          i;
    int          j;
    shuf_beat_t  beat;
    if (held_list.size() < DEPTH) held_list.push_back(value);
    else held_lost = 1'b1;
    if (!is_last) return;
    work = held_list;
    n = work.size();
    gen = gen_seed;
    for (i = n - 1; i > 0; i--) begin
      gen = gen * GEN_MUL + GEN_INC;
      j = int'(gen[31:16]) % (i + 1);
      tmp = work[i];
      work[i] = work[j];
      work[j] = tmp;
    end
    if (emit) begin
      for (i = 0; i < n; i++) begin
        beat.element = work[i];
        beat.last    = (i == n - 1);
        beat.ovf     = held_lost;
        expected_beats.push_back(beat);
      end
    end
    held_list.delete();
    held_lost = 1'b0;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic [31:0] value, input bit is_last);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= value;
    last     <= is_last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_list(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_beat($urandom, k == n - 1);
      shuffle_list(element, last, 1'b1);
    end
  endtask

  // The sender stops until every queued result has come back, then gives the
  // engine a little longer to go idle.
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gen_seed  = value;
  endtask

  // Output side: a fresh stall length is drawn after every accepted beat.
  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_valid) begin
        n = rx_eager ? 0 : $urandom_range(0, 6);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    shuf_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: element_res %h last_res %b overflow %b",
               element_res, last_res, overflow);
        faults++;
      end else begin
        want = expected_beats.pop_front();
        if (element_res !== want.element) begin
          $error("element_res: expected %h, got %h", want.element, element_res);
          faults++;
        end
        if (last_res !== want.last) begin
          $error("last_res: expected %b, got %b", want.last, last_res);
          faults++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, overflow);
          faults++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t   directed [DIR_N];
    logic [31:0] seeds [6];
    shuf_beat_t  beat;
    int          r;
    int          ph;
    int          phase_items;
    int          len;

    // Single-element lists come back untouched, so their results are typed in.
    directed = '{
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
      '{32'hAAAA_5555, 1'b1, 1'b1, 32'hAAAA_5555, 1'b1, 1'b0},
      '{32'h5555_AAAA, 1'b1, 1'b1, 32'h5555_AAAA, 1'b1, 1'b0},
      '{32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_000A, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_000B, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_000C, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_000D, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_000E, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0, 1'b0},
      '{32'h1234_5678, 1'b1, 1'b0, 32'h0, 1'b0, 1'b0}
    };
    seeds = '{32'hFFFF_FFFF, 32'h0000_0001, $urandom, 32'h8000_0000, $urandom,
              32'h0000_0000};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part runs with the seed left at its reset value.
    for (r = 0; r < DIR_N; r++) begin
      send_beat(directed[r].element, directed[r].last);
      if (directed[r].typed) begin
        shuffle_list(directed[r].element, directed[r].last, 1'b0);
        beat.element = directed[r].res_element;
        beat.last    = directed[r].res_last;
        beat.ovf     = directed[r].res_ovf;
        expected_beats.push_back(beat);
      end else begin
        shuffle_list(directed[r].element, directed[r].last, 1'b1);
      end
    end

    for (ph = 0; ph < 6; ph++) begin
      drain;
      write_seed(seeds[ph]);
      phase_items = 0;
      rx_eager = (ph == 3);
      tx_eager = (ph == 3);
      case (ph)
        0: send_list(DEPTH);
        1: begin
          // Hold the output off while short lists keep arriving back to back,
          // so the command queue fills and the input stalls.
          hold_output = 1'b1;
          tx_eager = 1'b1;
          repeat (5) send_list(4);
          tx_eager = 1'b0;
        end
        // The store fills and the closing beat itself is dropped.
        2: send_list(DEPTH + 2);
        default: ;
      endcase
      while (phase_items < 8) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_list(len);
        phase_items += len;
      end
    end

    drain;
    if (faults == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
